// ===== rtl/core/yaw_rotate_state_and_covariance_defines.svh =====
// Assertion macros shared by the checker of the yaw rotation block.
// Depends on nothing; expects signals named clock and reset where it is used.
`ifndef YAW_ROTATE_STATE_AND_COVARIANCE_DEFINES_SVH
`define YAW_ROTATE_STATE_AND_COVARIANCE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define YRSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define YRSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/yrsc_pkg.sv =====
// Package of the yaw rotation block: types, pipeline depths and trigonometric constants.
// Depends on nothing; used by every module of the block but the checker.
package yrsc_pkg;

   localparam int TRIG_BITS_DEF = 16;

   localparam int SIN_N = 6;
   localparam int COS_N = 7;
   localparam int unsigned SIN_DEN [SIN_N] = '{156, 110, 72, 42, 20, 6};
   localparam int unsigned COS_DEN [COS_N] = '{182, 132, 90, 56, 30, 12, 2};

   localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
   localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
   localparam logic [31:0] COV_INVALID = 32'h8000_0000;

   // Register stages from a transfer to the sine and cosine outputs.
   localparam int SC_LAT  = 17;
   // Stages up to the rotation unit input, and up to the result register.
   localparam int PAY_LAT = 19;
   localparam int LAT     = 21;

   typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] xx;
      logic signed [31:0] xy;
      logic signed [31:0] yy;
   } vec_in_type;

   typedef struct packed {
      logic signed [31:0] lng;
      logic signed [31:0] lat;
      logic signed [31:0] rxx;
      logic signed [31:0] rxy;
      logic signed [31:0] ryy;
   } vec_out_type;

   function automatic logic signed [31:0] cov_value(input logic [31:0] v);
      return (v == COV_INVALID) ? 32'sd0 : signed'(v);
   endfunction

endpackage

// ===== rtl/core/yrsc_cell.sv =====
// One Horner step of the series evaluator: a = 1 - (t2 * a) / K in Q30, over two stages.
// Depends on yrsc_pkg; chained inside yrsc_sincos.
module yrsc_cell #(
   parameter int unsigned K  = 2,
   parameter int          AW = 2
) (
   input  logic          clock,
   input  logic          en,
   input  logic [31:0]   t2_i,
   input  logic [30:0]   a_i,
   input  logic [AW-1:0] aux_i,
   output logic [31:0]   t2_o,
   output logic [30:0]   a_o,
   output logic [AW-1:0] aux_o
);
   import yrsc_pkg::*;

   localparam int          L  = $clog2(K);
   localparam int          SH = 32 + L;
   localparam logic [32:0] M  = 33'(((64'd1 << SH) + 64'(K) - 64'd1) / 64'(K));

   logic [31:0]   x_ff, x_in, t2a_ff, t2b_ff;
   logic [AW-1:0] auxa_ff, auxb_ff;
   logic [30:0]   a_ff, a_in;
   logic [62:0]   prod;
   logic [64:0]   qprod, quot;

   always_comb begin
      prod  = 63'(t2_i) * 63'(a_i);
      x_in  = prod[61:30];
      qprod = 65'(x_ff) * 65'(M);
      quot  = qprod >> SH;
      a_in  = 31'(ONE_Q30 - quot[31:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         t2a_ff  <= t2_i;
         auxa_ff <= aux_i;
         a_ff    <= a_in;
         t2b_ff  <= t2a_ff;
         auxb_ff <= auxa_ff;
      end
   end

   assign t2_o  = t2b_ff;
   assign a_o   = a_ff;
   assign aux_o = auxb_ff;

endmodule

// ===== rtl/core/yrsc_sincos.sv =====
// Pipelined sine and cosine of a 17-bit phase in Q30, built from two chains of Horner cells.
// Depends on yrsc_pkg and yrsc_cell.
module yrsc_sincos (
   input  logic               clock,
   input  logic               en,
   input  logic [16:0]        phase,
   output logic signed [31:0] sin_q30,
   output logic signed [31:0] cos_q30
);
   import yrsc_pkg::*;

   logic [30:0] t_ff, t_in, t2t_ff;
   logic [31:0] t2_ff, t2_in;
   quad_type    q1_ff, q2_ff;
   logic [45:0] tprod;
   logic [61:0] t2prod, sprod;

   logic [31:0] s_t2  [SIN_N+1];
   logic [30:0] s_a   [SIN_N+1];
   logic [30:0] s_aux [SIN_N+1];
   logic [31:0] c_t2  [COS_N+1];
   logic [30:0] c_a   [COS_N+1];
   logic [1:0]  c_aux [COS_N+1];

   logic [30:0] s_ff, s_in, s2_ff;
   logic signed [31:0] sn_ff, sn_in, cs_ff, cs_in, sp, cp;

   always_comb begin
      tprod  = 46'(phase[14:0]) * 46'(PI_HALF_Q30);
      t_in   = tprod[45:15];
      t2prod = 62'(t_ff) * 62'(t_ff);
      t2_in  = t2prod[61:30];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff   <= t_in;
         q1_ff  <= quad_type'(phase[16:15]);
         t2_ff  <= t2_in;
         t2t_ff <= t_ff;
         q2_ff  <= q1_ff;
      end
   end

   assign s_t2[0]  = t2_ff;
   assign s_a[0]   = ONE_Q30[30:0];
   assign s_aux[0] = t2t_ff;
   assign c_t2[0]  = t2_ff;
   assign c_a[0]   = ONE_Q30[30:0];
   assign c_aux[0] = q2_ff;

   for (genvar g = 0; g < SIN_N; g++) begin : g_sin
      yrsc_cell #(.K(SIN_DEN[g]), .AW(31)) u_cell (
         .clock(clock), .en(en),
         .t2_i(s_t2[g]), .a_i(s_a[g]), .aux_i(s_aux[g]),
         .t2_o(s_t2[g+1]), .a_o(s_a[g+1]), .aux_o(s_aux[g+1])
      );
   end

   for (genvar g = 0; g < COS_N; g++) begin : g_cos
      yrsc_cell #(.K(COS_DEN[g]), .AW(2)) u_cell (
         .clock(clock), .en(en),
         .t2_i(c_t2[g]), .a_i(c_a[g]), .aux_i(c_aux[g]),
         .t2_o(c_t2[g+1]), .a_o(c_a[g+1]), .aux_o(c_aux[g+1])
      );
   end

   always_comb begin
      sprod = 62'(s_aux[SIN_N]) * 62'(s_a[SIN_N]);
      s_in  = sprod[60:30];
      sp    = signed'(32'(s2_ff));
      cp    = signed'(32'(c_a[COS_N]));
      case (quad_type'(c_aux[COS_N]))
         QUAD_I: begin
            sn_in = sp;
            cs_in = cp;
         end
         QUAD_II: begin
            sn_in = cp;
            cs_in = -sp;
         end
         QUAD_III: begin
            sn_in = -sp;
            cs_in = -cp;
         end
         default: begin
            sn_in = -cp;
            cs_in = sp;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff  <= s_in;
         s2_ff <= s_ff;
         sn_ff <= sn_in;
         cs_ff <= cs_in;
      end
   end

   assign sin_q30 = sn_ff;
   assign cos_q30 = cs_ff;

endmodule

// ===== rtl/core/yrsc_rotate.sv =====
// Rotation of one vector and its 2x2 covariance by the yaw terms, two register stages.
// Depends on yrsc_pkg.
module yrsc_rotate #(
   parameter int TRIG_BITS = yrsc_pkg::TRIG_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      en,
   input  yrsc_pkg::vec_in_type      vin,
   input  logic signed [TRIG_BITS+1:0] c,
   input  logic signed [TRIG_BITS+1:0] s,
   input  logic signed [TRIG_BITS+1:0] cc,
   input  logic signed [TRIG_BITS+1:0] ss,
   input  logic signed [TRIG_BITS+1:0] sc,
   output yrsc_pkg::vec_out_type     vout
);
   import yrsc_pkg::*;

   localparam int CW = TRIG_BITS + 2;
   localparam int SW = TRIG_BITS + 36;

   localparam logic signed [SW:0] MAXV = (SW+1)'(32'sh7FFF_FFFF);
   localparam logic signed [SW:0] MINV = (SW+1)'(-64'sd2147483648);
   localparam logic signed [SW:0] HALF = (SW+1)'(64'sd1 <<< (TRIG_BITS - 1));

   logic signed [SW-1:0] cx_ff, sy_ff, cy_ff, sx_ff, xxcc_ff, yyss_ff, xysc_ff;
   logic signed [SW-1:0] dsc_ff, xyd_ff, xxss_ff, yycc_ff;
   logic signed [32:0]   dxy;
   logic signed [CW:0]   dcs;
   vec_out_type          out_ff, out_in;

   function automatic logic signed [31:0] fin(input logic signed [SW-1:0] v);
      logic signed [SW:0] r;
      logic signed [SW:0] sh;
      r  = (SW+1)'(v) + HALF;
      sh = r >>> TRIG_BITS;
      if (sh > MAXV) begin
         return 32'sh7FFF_FFFF;
      end else if (sh < MINV) begin
         return 32'sh8000_0000;
      end
      return 32'(sh);
   endfunction

   always_comb begin
      dxy = 33'(vin.yy) - 33'(vin.xx);
      dcs = (CW+1)'(cc) - (CW+1)'(ss);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff   <= SW'(c * vin.x);
         sy_ff   <= SW'(s * vin.y);
         cy_ff   <= SW'(c * vin.y);
         sx_ff   <= SW'(s * vin.x);
         xxcc_ff <= SW'(vin.xx * cc);
         yyss_ff <= SW'(vin.yy * ss);
         xysc_ff <= SW'(vin.xy * sc);
         dsc_ff  <= SW'(dxy * sc);
         xyd_ff  <= SW'(vin.xy * dcs);
         xxss_ff <= SW'(vin.xx * ss);
         yycc_ff <= SW'(vin.yy * cc);
      end
   end

   always_comb begin
      out_in.lng = fin(cx_ff + sy_ff);
      out_in.lat = fin(cy_ff - sx_ff);
      out_in.rxx = fin(xxcc_ff + yyss_ff + (xysc_ff <<< 1));
      out_in.rxy = fin(dsc_ff + xyd_ff);
      out_in.ryy = fin(xxss_ff + yycc_ff - (xysc_ff <<< 1));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign vout = out_ff;

endmodule

// ===== rtl/core/yaw_rotate_state_and_covariance.sv =====
// Top level of the yaw rotation block for radar objects.
// Depends on yrsc_pkg, yrsc_sincos and yrsc_rotate.
//
// One object arrives per transfer on the req_ channel: a yaw in 1/65536 turn, a
// velocity and an acceleration vector and their covariance terms in Q16.16. One
// result leaves per object on the rsp_ channel: both vectors rotated into the
// object frame, both covariances rotated as R Sigma R^T, and the half-yaw
// quaternion terms in Q1.15. A covariance code of 0x80000000 is read as zero.
// From an input transfer to the result becoming valid, an object passes the sine
// and cosine units (the phase scaling and its square, the chains of Horner cells
// and the quadrant), the rounding of the yaw terms, their squares and the rotation
// multipliers. Throughput is one object per cycle while the result is not stalled.
// While the result register holds a result that the receiver stalls, the whole
// pipeline holds and req_stall is high; otherwise every stage moves each cycle.
// Synchronous reset clears all valid flags; no result is pending afterwards.
module yaw_rotate_state_and_covariance #(
   parameter int TRIG_BITS = yrsc_pkg::TRIG_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_yaw_angle,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_cov_xx,
   input  logic signed [31:0] req_vel_cov_xy,
   input  logic signed [31:0] req_vel_cov_yy,
   input  logic signed [31:0] req_acc_x,
   input  logic signed [31:0] req_acc_y,
   input  logic signed [31:0] req_acc_cov_xx,
   input  logic signed [31:0] req_acc_cov_xy,
   input  logic signed [31:0] req_acc_cov_yy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_vel_long,
   output logic signed [31:0] rsp_vel_lat,
   output logic signed [31:0] rsp_vel_rot_xx,
   output logic signed [31:0] rsp_vel_rot_xy,
   output logic signed [31:0] rsp_vel_rot_yy,
   output logic signed [31:0] rsp_acc_long,
   output logic signed [31:0] rsp_acc_lat,
   output logic signed [31:0] rsp_acc_rot_xx,
   output logic signed [31:0] rsp_acc_rot_xy,
   output logic signed [31:0] rsp_acc_rot_yy,
   output logic signed [15:0] rsp_quat_z,
   output logic signed [15:0] rsp_quat_w
);
   import yrsc_pkg::*;

   localparam int CW   = TRIG_BITS + 2;
   localparam int NSH  = 30 - TRIG_BITS;
   localparam int QLAT = LAT - SC_LAT;

   localparam logic signed [32:0]     TRIG_HALF = 33'sd1 <<< (NSH - 1);
   localparam logic signed [2*CW-1:0] SQ_HALF   = (2*CW)'(64'sd1 <<< (TRIG_BITS - 1));

   logic           adv;
   logic [LAT-1:0] vld_ff;

   vec_in_type vel_ff [PAY_LAT];
   vec_in_type acc_ff [PAY_LAT];

   logic signed [31:0] fs, fc, hs, hc;
   logic signed [CW-1:0] c_ff, c_in, s_ff, s_in, c2_ff, s2_ff;
   logic signed [CW-1:0] cc_ff, cc_in, ss_ff, ss_in, sc_ff, sc_in;
   logic signed [15:0] qz_ff [QLAT];
   logic signed [15:0] qw_ff [QLAT];
   logic signed [2*CW-1:0] cc_p, ss_p, sc_p;
   vec_out_type vel_out, acc_out;

   function automatic logic signed [CW-1:0] trig_round(input logic signed [31:0] v);
      logic signed [32:0] r;
      r = 33'(v) + TRIG_HALF;
      return CW'(r >>> NSH);
   endfunction

   function automatic logic signed [CW-1:0] sq_round(input logic signed [2*CW-1:0] v);
      logic signed [2*CW-1:0] r;
      r = v + SQ_HALF;
      return CW'(r >>> TRIG_BITS);
   endfunction

   function automatic logic signed [15:0] quat_round(input logic signed [31:0] v);
      logic signed [32:0] r;
      logic signed [32:0] sh;
      r  = 33'(v) + 33'sd16384;
      sh = r >>> 15;
      if (sh > 33'sd32767) begin
         return 16'sh7FFF;
      end else if (sh < -33'sd32768) begin
         return 16'sh8000;
      end
      return 16'(sh);
   endfunction

   assign adv       = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vel_ff[0].x  <= req_vel_x;
         vel_ff[0].y  <= req_vel_y;
         vel_ff[0].xx <= cov_value(req_vel_cov_xx);
         vel_ff[0].xy <= cov_value(req_vel_cov_xy);
         vel_ff[0].yy <= cov_value(req_vel_cov_yy);
         acc_ff[0].x  <= req_acc_x;
         acc_ff[0].y  <= req_acc_y;
         acc_ff[0].xx <= cov_value(req_acc_cov_xx);
         acc_ff[0].xy <= cov_value(req_acc_cov_xy);
         acc_ff[0].yy <= cov_value(req_acc_cov_yy);
         for (int i = 1; i < PAY_LAT; i++) begin
            vel_ff[i] <= vel_ff[i-1];
            acc_ff[i] <= acc_ff[i-1];
         end
      end
   end

   yrsc_sincos u_full (
      .clock(clock), .en(adv), .phase({req_yaw_angle, 1'b0}),
      .sin_q30(fs), .cos_q30(fc)
   );

   yrsc_sincos u_half (
      .clock(clock), .en(adv), .phase({1'b0, req_yaw_angle}),
      .sin_q30(hs), .cos_q30(hc)
   );

   always_comb begin
      c_in  = trig_round(fc);
      s_in  = trig_round(fs);
      cc_p  = c_ff * c_ff;
      ss_p  = s_ff * s_ff;
      sc_p  = s_ff * c_ff;
      cc_in = sq_round(cc_p);
      ss_in = sq_round(ss_p);
      sc_in = sq_round(sc_p);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff     <= c_in;
         s_ff     <= s_in;
         c2_ff    <= c_ff;
         s2_ff    <= s_ff;
         cc_ff    <= cc_in;
         ss_ff    <= ss_in;
         sc_ff    <= sc_in;
         qz_ff[0] <= quat_round(hs);
         qw_ff[0] <= quat_round(hc);
         for (int i = 1; i < QLAT; i++) begin
            qz_ff[i] <= qz_ff[i-1];
            qw_ff[i] <= qw_ff[i-1];
         end
      end
   end

   yrsc_rotate #(.TRIG_BITS(TRIG_BITS)) u_vel (
      .clock(clock), .en(adv), .vin(vel_ff[PAY_LAT-1]),
      .c(c2_ff), .s(s2_ff), .cc(cc_ff), .ss(ss_ff), .sc(sc_ff), .vout(vel_out)
   );

   yrsc_rotate #(.TRIG_BITS(TRIG_BITS)) u_acc (
      .clock(clock), .en(adv), .vin(acc_ff[PAY_LAT-1]),
      .c(c2_ff), .s(s2_ff), .cc(cc_ff), .ss(ss_ff), .sc(sc_ff), .vout(acc_out)
   );

   assign rsp_vel_long   = vel_out.lng;
   assign rsp_vel_lat    = vel_out.lat;
   assign rsp_vel_rot_xx = vel_out.rxx;
   assign rsp_vel_rot_xy = vel_out.rxy;
   assign rsp_vel_rot_yy = vel_out.ryy;
   assign rsp_acc_long   = acc_out.lng;
   assign rsp_acc_lat    = acc_out.lat;
   assign rsp_acc_rot_xx = acc_out.rxx;
   assign rsp_acc_rot_xy = acc_out.rxy;
   assign rsp_acc_rot_yy = acc_out.ryy;
   assign rsp_quat_z     = qz_ff[QLAT-1];
   assign rsp_quat_w     = qw_ff[QLAT-1];

endmodule

// ===== rtl/core/yrsc_checker.sv =====
// Port-level checker of the yaw rotation block and the bind that attaches it.
// Depends on yaw_rotate_state_and_covariance_defines.svh.
`include "yaw_rotate_state_and_covariance_defines.svh"

module yrsc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_vel_long,
   input logic signed [15:0] rsp_quat_w
);

   `YRSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "Stalled result was dropped.")
   `YRSC_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall,
                     $stable(rsp_vel_long) && $stable(rsp_quat_w), "Stalled result changed.")
   `YRSC_ASSERT_NOW(a_backpressure, rsp_valid && rsp_stall, req_stall,
                    "Input taken while the result register is blocked.")
   `YRSC_ASSERT_NOW(a_free_flow, !rsp_valid, !req_stall,
                    "Input stalled although the result register is empty.")

endmodule

bind yaw_rotate_state_and_covariance yrsc_checker u_yrsc_checker (.*);
